// ===== hw/rtl/crc_text_frame_checker_core_macros.svh =====
// Assertion macros for the CRC text frame checker; clk and rst_n are taken from the caller.
`ifndef CRC_TEXT_FRAME_CHECKER_CORE_MACROS_SVH
`define CRC_TEXT_FRAME_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CTF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CTF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ctf_pkg.sv =====
// Shared types, codes and CRC helper for the CRC text frame checker.
package ctf_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_STAR  = 3'd1;
  localparam logic [2:0] ST_BAD_LEN  = 3'd2;
  localparam logic [2:0] ST_BAD_HEX  = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  CH_STAR  = 8'h2A;
  localparam logic [7:0]  CH_SPACE = 8'h20;

  // Tail length only matters as "exactly four", so it saturates just past that.
  localparam int unsigned TAIL_CAP = 5;
  localparam logic [2:0]  TAIL_FOUR = 3'd4;

  // One classified byte as it waits between front and back.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       ws;
    logic       star;
    logic       space;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       line_end;
  } ctf_item_t;

  // CRC-16 MSB first, one byte per call, fully unrolled.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/ctf_if.sv =====
// Valid/ready channel interfaces for input bytes and line results.
interface ctf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       line_end;

  modport source (output valid, output char_byte, output line_end, input ready);
  modport sink   (input valid, input char_byte, input line_end, output ready);
endinterface

interface ctf_out_if #(parameter int LEN_W = 9);
  logic             valid;
  logic             ready;
  logic             frame_ok;
  logic [2:0]       status;
  logic [15:0]      received_crc;
  logic [15:0]      computed_crc;
  logic [LEN_W-1:0] payload_length;
  logic [7:0]       token_count;

  modport source (output valid, output frame_ok, output status, output received_crc,
                  output computed_crc, output payload_length, output token_count,
                  input ready);
  modport sink   (input valid, input frame_ok, input status, input received_crc,
                  input computed_crc, input payload_length, input token_count,
                  output ready);
endinterface

// ===== hw/rtl/ctf_front.sv =====
// Front end: classifies each byte and holds it in a two-entry queue for the back end.
module ctf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char_byte,
  input  logic               in_line_end,
  output logic               q_valid,
  output ctf_pkg::ctf_item_t q_item,
  input  logic               q_pop
);
  import ctf_pkg::*;

  ctf_item_t  cls;
  ctf_item_t  q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;

  always_comb begin
    cls           = '0;
    cls.char_byte = in_char_byte;
    cls.line_end  = in_line_end;
    cls.space     = (in_char_byte == CH_SPACE);
    cls.star      = (in_char_byte == CH_STAR);
    cls.ws        = cls.space || (in_char_byte >= 8'h09 && in_char_byte <= 8'h0D);
    if (in_char_byte >= "0" && in_char_byte <= "9") begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(in_char_byte - 8'h30);
    end else if (in_char_byte >= "a" && in_char_byte <= "f") begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(in_char_byte - 8'h57);
    end else if (in_char_byte >= "A" && in_char_byte <= "F") begin
      cls.hex_ok  = 1'b1;
      cls.hex_val = 4'(in_char_byte - 8'h37);
    end
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= cls;
  end

endmodule

// ===== hw/rtl/ctf_back.sv =====
// Back end: per-line CRC, length, token and tail tracking, plus the result register.
module ctf_back #(
  parameter int MAX_LINE = 256,
  parameter int LEN_W    = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ctf_pkg::ctf_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_frame_ok,
  output logic [2:0]         out_status,
  output logic [15:0]        out_received_crc,
  output logic [15:0]        out_computed_crc,
  output logic [LEN_W-1:0]   out_payload_length,
  output logic [7:0]         out_token_count
);
  import ctf_pkg::*;

  localparam int         TOKEN_CAP_I = ((MAX_LINE / 2) < 255) ? (MAX_LINE / 2) : 255;
  localparam logic [7:0] TOKEN_CAP   = 8'(TOKEN_CAP_I);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_LINE);
  localparam logic [2:0] TAIL_MAX    = 3'(TAIL_CAP);

  logic [15:0]      crc_run_r, crc_run_nxt, crc_ln_r, crc_ln_nxt, crc_star_r, crc_star_nxt;
  logic [LEN_W-1:0] len_run_r, len_run_nxt, len_ln_r, len_ln_nxt, len_star_r, len_star_nxt;
  logic [7:0]       tok_run_r, tok_run_nxt, tok_ln_r, tok_ln_nxt, tok_star_r, tok_star_nxt;
  logic             started_r, started_nxt, star_seen_r, star_seen_nxt;
  logic             prev_sp_r, prev_sp_nxt;
  logic             tail_started_r, tail_started_nxt, gap_r, gap_nxt;
  logic             not_hex_r, not_hex_nxt;
  logic [2:0]       tlen_run_r, tlen_run_nxt, tlen_trim_r, tlen_trim_nxt;
  logic [15:0]      hexval_r, hexval_nxt;

  logic             res_ok;
  logic [2:0]       res_status;
  logic [15:0]      res_rcv, res_cmp;
  logic [LEN_W-1:0] res_len;
  logic [7:0]       res_tok;

  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r;
  logic [2:0]       out_status_r;
  logic [15:0]      out_rcv_r, out_cmp_r;
  logic [LEN_W-1:0] out_len_r;
  logic [7:0]       out_tok_r;

  // A byte with no result never waits for the output register.
  assign q_pop = q_valid && (!q_item.line_end || !out_valid_r || out_ready);

  always_comb begin
    crc_run_nxt      = crc_run_r;
    crc_ln_nxt       = crc_ln_r;
    crc_star_nxt     = crc_star_r;
    len_run_nxt      = len_run_r;
    len_ln_nxt       = len_ln_r;
    len_star_nxt     = len_star_r;
    tok_run_nxt      = tok_run_r;
    tok_ln_nxt       = tok_ln_r;
    tok_star_nxt     = tok_star_r;
    started_nxt      = started_r | ~q_item.ws;
    star_seen_nxt    = star_seen_r;
    prev_sp_nxt      = prev_sp_r;
    tail_started_nxt = tail_started_r;
    gap_nxt          = gap_r;
    not_hex_nxt      = not_hex_r;
    tlen_run_nxt     = tlen_run_r;
    tlen_trim_nxt    = tlen_trim_r;
    hexval_nxt       = hexval_r;

    if (started_nxt) begin
      if (q_item.star) begin
        // snapshot the payload as it stood at its last non-whitespace byte
        crc_star_nxt     = crc_ln_r;
        len_star_nxt     = len_ln_r;
        tok_star_nxt     = tok_ln_r;
        star_seen_nxt    = 1'b1;
        tail_started_nxt = 1'b0;
        gap_nxt          = 1'b0;
        not_hex_nxt      = 1'b0;
        tlen_run_nxt     = '0;
        tlen_trim_nxt    = '0;
        hexval_nxt       = '0;
      end else if (star_seen_r) begin
        if (q_item.ws) begin
          if (tail_started_r) begin
            gap_nxt      = 1'b1;
            tlen_run_nxt = (tlen_run_r < TAIL_MAX) ? tlen_run_r + 3'd1 : TAIL_MAX;
          end
        end else begin
          tail_started_nxt = 1'b1;
          // whitespace inside the trimmed tail poisons it
          not_hex_nxt      = not_hex_r | gap_r | ~q_item.hex_ok;
          gap_nxt          = 1'b0;
          tlen_run_nxt     = (tlen_run_r < TAIL_MAX) ? tlen_run_r + 3'd1 : TAIL_MAX;
          tlen_trim_nxt    = tlen_run_nxt;
          if (q_item.hex_ok) hexval_nxt = {hexval_r[11:0], q_item.hex_val};
        end
      end

      crc_run_nxt = crc_byte(crc_run_r, q_item.char_byte);
      len_run_nxt = (len_run_r < LEN_CAP) ? len_run_r + LEN_W'(1) : LEN_CAP;
      if (!q_item.space && prev_sp_r)
        tok_run_nxt = (tok_run_r < TOKEN_CAP) ? tok_run_r + 8'd1 : TOKEN_CAP;
      prev_sp_nxt = q_item.space;
      if (!q_item.ws) begin
        crc_ln_nxt = crc_run_nxt;
        len_ln_nxt = len_run_nxt;
        tok_ln_nxt = tok_run_nxt;
      end
    end

    res_rcv = '0;
    if (!star_seen_nxt) begin
      res_status = ST_NO_STAR;
      res_cmp    = crc_ln_nxt;
      res_len    = len_ln_nxt;
      res_tok    = tok_ln_nxt;
    end else begin
      res_cmp = crc_star_nxt;
      res_len = len_star_nxt;
      res_tok = tok_star_nxt;
      priority if (tlen_trim_nxt != TAIL_FOUR) begin
        res_status = ST_BAD_LEN;
      end else if (not_hex_nxt) begin
        res_status = ST_BAD_HEX;
      end else begin
        res_rcv    = hexval_nxt;
        res_status = (hexval_nxt == crc_star_nxt) ? ST_OK : ST_MISMATCH;
      end
    end
    res_ok = (res_status == ST_OK);

    if (q_pop && q_item.line_end) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (q_pop && q_item.line_end)) begin
      crc_run_r      <= CRC_INIT;
      crc_ln_r       <= CRC_INIT;
      crc_star_r     <= CRC_INIT;
      len_run_r      <= '0;
      len_ln_r       <= '0;
      len_star_r     <= '0;
      tok_run_r      <= '0;
      tok_ln_r       <= '0;
      tok_star_r     <= '0;
      started_r      <= 1'b0;
      star_seen_r    <= 1'b0;
      prev_sp_r      <= 1'b1;
      tail_started_r <= 1'b0;
      gap_r          <= 1'b0;
      not_hex_r      <= 1'b0;
      tlen_run_r     <= '0;
      tlen_trim_r    <= '0;
      hexval_r       <= '0;
    end else if (q_pop) begin
      crc_run_r      <= crc_run_nxt;
      crc_ln_r       <= crc_ln_nxt;
      crc_star_r     <= crc_star_nxt;
      len_run_r      <= len_run_nxt;
      len_ln_r       <= len_ln_nxt;
      len_star_r     <= len_star_nxt;
      tok_run_r      <= tok_run_nxt;
      tok_ln_r       <= tok_ln_nxt;
      tok_star_r     <= tok_star_nxt;
      started_r      <= started_nxt;
      star_seen_r    <= star_seen_nxt;
      prev_sp_r      <= prev_sp_nxt;
      tail_started_r <= tail_started_nxt;
      gap_r          <= gap_nxt;
      not_hex_r      <= not_hex_nxt;
      tlen_run_r     <= tlen_run_nxt;
      tlen_trim_r    <= tlen_trim_nxt;
      hexval_r       <= hexval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.line_end) begin
      out_ok_r     <= res_ok;
      out_status_r <= res_status;
      out_rcv_r    <= res_rcv;
      out_cmp_r    <= res_cmp;
      out_len_r    <= res_len;
      out_tok_r    <= res_tok;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_ok       = out_ok_r;
  assign out_status         = out_status_r;
  assign out_received_crc   = out_rcv_r;
  assign out_computed_crc   = out_cmp_r;
  assign out_payload_length = out_len_r;
  assign out_token_count    = out_tok_r;

endmodule

// ===== hw/rtl/crc_text_frame_checker_core.sv =====
// Top level of the CRC text frame checker: front classifier, queue, back tracker.
//
//   channel   | dir | handshake         | payload
//   in_chan   | in  | valid/ready       | char_byte[7:0], line_end
//   out_chan  | out | valid/ready       | frame_ok, status, received_crc, computed_crc,
//             |     |                   | payload_length, token_count
//
// One byte per clock sustained while no line_end byte stalls behind an untaken result;
// the byte-wide CRC update in the back end sets that figure. A line's result is registered
// after its line_end byte is accepted, passing the queue entry, then the result register.
// Reset clears all control state at once; no clearing pass, ready right after reset.
// The two-entry queue keeps accepting bytes while a result waits, until it fills; only a line_end byte
// stalls behind an untaken result.
module crc_text_frame_checker_core #(
  parameter int MAX_LINE = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  ctf_in_if.sink        in_chan,
  ctf_out_if.source     out_chan
);
  import ctf_pkg::*;

  localparam int LEN_W = $clog2(MAX_LINE + 1);

  logic      q_valid;
  logic      q_pop;
  ctf_item_t q_item;

  ctf_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_char_byte (in_chan.char_byte),
    .in_line_end  (in_chan.line_end),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  ctf_back #(
    .MAX_LINE (MAX_LINE),
    .LEN_W    (LEN_W)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_valid          (out_chan.valid),
    .out_ready          (out_chan.ready),
    .out_frame_ok       (out_chan.frame_ok),
    .out_status         (out_chan.status),
    .out_received_crc   (out_chan.received_crc),
    .out_computed_crc   (out_chan.computed_crc),
    .out_payload_length (out_chan.payload_length),
    .out_token_count    (out_chan.token_count)
  );

`include "crc_text_frame_checker_core_macros.svh"

  `CTF_ASSERT_IMP(a_ok_flag, out_chan.valid, out_chan.frame_ok == (out_chan.status == ST_OK), "frame_ok disagrees with status")
  `CTF_ASSERT_IMP(a_rcv_zero, out_chan.valid && (out_chan.status == ST_NO_STAR || out_chan.status == ST_BAD_LEN || out_chan.status == ST_BAD_HEX), out_chan.received_crc == 16'h0000, "received_crc set on unparsed tail")
  `CTF_ASSERT_IMP(a_len_cap, out_chan.valid, out_chan.payload_length <= LEN_W'(MAX_LINE), "payload_length above cap")
  `CTF_ASSERT_NXT(a_end_result, q_pop && q_item.line_end, out_chan.valid, "line end popped without result")

endmodule
